// ===== hdl/rmth_pkg.sv =====
// rmth_pkg: shared types and constants for the running median block
// no dependencies

package rmth_pkg;

    // sequencer operations for the heap engine
    typedef enum logic [1:0] {
        HOP_PUSH    = 2'd0,
        HOP_REPLACE = 2'd1
    } heap_op_t;

    localparam int MEDIAN_W = 17;
    localparam int COUNT_W  = 11;

endpackage

// ===== hdl/running_median_two_heap.sv =====
// Running lower median over two heaps. One item (start while not busy) inserts a value;
// one result follows with a strobe (done) for exactly one cycle and cannot be stalled.
// A shared compare unit walks the heap memories one level per step, with a read, a wait and a
// compare. A dropped item skips the heaps. A plain push sifts up in one heap. When a top
// moves across, a replace (sift down) runs before the push (sift up) into the other heap.
// Depends on rmth_pkg.

module running_median_two_heap
    import rmth_pkg::*;
#(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 17
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  busy,
    output logic                  done,
    output logic [MEDIAN_W-1:0]   median,
    output logic [COUNT_W-1:0]    held_count,
    output logic                  dropped
);

    localparam int LDEPTH = (CAPACITY + 1) / 2;
    localparam int UDEPTH = CAPACITY / 2;
    localparam int AW     = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
    localparam int SW     = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_RD_TOPS, S_SD_RD, S_SD_WAIT, S_SD_CMP,
        S_SU_RD, S_SU_WAIT, S_SU_CMP, S_DONE
    } state_t;

    // heap memories, lower is max-heap, upper is min-heap
    logic [VALUE_BITS-1:0] lmem [LDEPTH];
    logic [VALUE_BITS-1:0] umem [UDEPTH];

    state_t                state_reg, state_next;
    logic [SW-1:0]         lsize_reg, lsize_next, usize_reg, usize_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;       // value being placed
    logic [VALUE_BITS-1:0] carry_reg, carry_next; // value pushed after replace
    logic [VALUE_BITS-1:0] ltop_reg, ltop_next;  // cached lower top
    logic [VALUE_BITS-1:0] utop_reg, utop_next;
    logic [AW:0]           idx_reg, idx_next;
    logic [AW:0]           n_reg, n_next;        // active heap size for sift down
    logic                  side_reg, side_next;  // 1: lower heap
    logic                  push_side_reg, push_side_next;
    heap_op_t              op_reg, op_next;
    logic                  drop_reg, drop_next;
    logic                  done_reg, done_next;

    // two read addresses and one write port per memory, shared by the sequencer
    logic [AW-1:0]         ra0, ra1;
    logic [VALUE_BITS-1:0] rd0_reg, rd1_reg;
    logic                  we;
    logic [AW-1:0]         wa;
    logic [VALUE_BITS-1:0] wd;

    // memory read port 0 and 1 on the active heap; one write
    always_ff @(posedge clk)
    begin
        if (side_reg)
        begin
            rd0_reg <= lmem[ra0];
            rd1_reg <= lmem[ra1];
        end
        else
        begin
            rd0_reg <= umem[ra0];
            rd1_reg <= umem[ra1];
        end
        if (we)
        begin
            if (side_reg) lmem[wa] <= wd;
            else          umem[wa] <= wd;
        end
    end

    // shared compare: a sits above b in the active heap
    function automatic logic above(input logic [VALUE_BITS-1:0] a,
                                   input logic [VALUE_BITS-1:0] b,
                                   input logic is_max);
        above = is_max ? (a > b) : (a < b);
    endfunction

    logic [AW+1:0] lch, rch;
    logic [AW:0]   par;
    logic [VALUE_BITS-1:0] cur_val, best_val;
    logic          pick_l, pick_r, lv, rv;

    always_comb
    begin
        state_next     = state_reg;
        lsize_next     = lsize_reg;
        usize_next     = usize_reg;
        v_next         = v_reg;
        carry_next     = carry_reg;
        ltop_next      = ltop_reg;
        utop_next      = utop_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        side_next      = side_reg;
        push_side_next = push_side_reg;
        op_next        = op_reg;
        drop_next      = drop_reg;
        done_next      = 1'b0;
        ra0 = '0; ra1 = '0;
        we = 1'b0; wa = '0; wd = '0;
        lch = {idx_reg, 1'b1};
        rch = lch + 1'b1;
        par = (idx_reg - 1'b1) >> 1;
        lv = 1'b0; rv = 1'b0; pick_l = 1'b0; pick_r = 1'b0;
        cur_val = v_reg; best_val = v_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !done_reg)
                begin
                    v_next    = value;
                    drop_next = 1'b0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_SU_RD;
                op_next    = HOP_PUSH;
                if (SW'(lsize_reg + usize_reg) >= SW'(CAPACITY))
                begin
                    drop_next  = 1'b1;
                    state_next = S_DONE;
                end
                else if (lsize_reg == '0 || v_reg <= ltop_reg)
                begin
                    if (lsize_reg > usize_reg)
                    begin
                        if (v_reg < ltop_reg)
                        begin
                            // replace lower top, then push old top upward
                            carry_next     = ltop_reg;
                            side_next      = 1'b1;
                            push_side_next = 1'b0;
                            op_next        = HOP_REPLACE;
                            n_next         = (AW+1)'(lsize_reg);
                            state_next     = S_SD_RD;
                        end
                        else
                        begin
                            side_next = 1'b0;
                        end
                    end
                    else
                    begin
                        side_next = 1'b1;
                    end
                end
                else if (usize_reg >= lsize_reg)
                begin
                    if (usize_reg == '0 || v_reg <= utop_reg)
                    begin
                        side_next = 1'b1;
                    end
                    else
                    begin
                        carry_next     = utop_reg;
                        side_next      = 1'b0;
                        push_side_next = 1'b1;
                        op_next        = HOP_REPLACE;
                        n_next         = (AW+1)'(usize_reg);
                        state_next     = S_SD_RD;
                    end
                end
                else
                begin
                    side_next = 1'b0;
                end
                idx_next = '0;
                if (state_next == S_SU_RD)
                begin
                    // place at the end and start sifting up
                    idx_next = side_next ? (AW+1)'(lsize_reg) : (AW+1)'(usize_reg);
                    if (side_next) lsize_next = lsize_reg + 1'b1;
                    else           usize_next = usize_reg + 1'b1;
                end
            end
            // sift down from idx with v_reg as the value being placed
            S_SD_RD:
            begin
                ra0 = AW'(lch);
                ra1 = AW'(rch);
                state_next = S_SD_WAIT;
            end
            S_SD_WAIT:
            begin
                // keep the child addresses so the read data holds
                ra0 = AW'(lch);
                ra1 = AW'(rch);
                state_next = S_SD_CMP;
            end
            S_SD_CMP:
            begin
                lv = lch < {1'b0, n_reg};
                rv = rch < {1'b0, n_reg};
                best_val = v_reg;
                if (lv && above(rd0_reg, best_val, side_reg))
                begin
                    pick_l = 1'b1; best_val = rd0_reg;
                end
                if (rv && above(rd1_reg, best_val, side_reg))
                begin
                    pick_r = 1'b1; pick_l = 1'b0; best_val = rd1_reg;
                end
                we = 1'b1;
                wa = AW'(idx_reg);
                wd = best_val;
                if (idx_reg == '0)
                begin
                    if (side_reg) ltop_next = best_val;
                    else          utop_next = best_val;
                end
                if (pick_l || pick_r)
                begin
                    idx_next   = pick_r ? (AW+1)'(rch) : (AW+1)'(lch);
                    state_next = S_SD_RD;
                end
                else
                begin
                    // now push the displaced top into the other heap
                    v_next    = carry_reg;
                    side_next = push_side_reg;
                    op_next   = HOP_PUSH;
                    if (push_side_reg)
                    begin
                        idx_next   = (AW+1)'(lsize_reg);
                        lsize_next = lsize_reg + 1'b1;
                    end
                    else
                    begin
                        idx_next   = (AW+1)'(usize_reg);
                        usize_next = usize_reg + 1'b1;
                    end
                    state_next = S_SU_RD;
                end
            end
            // sift up: compare v_reg with the parent of idx
            S_SU_RD:
            begin
                ra0 = AW'(par);
                state_next = S_SU_WAIT;
            end
            S_SU_WAIT:
            begin
                // keep the parent address so the read data holds
                ra0 = AW'(par);
                state_next = S_SU_CMP;
            end
            S_SU_CMP:
            begin
                cur_val = rd0_reg;
                we = 1'b1;
                wa = AW'(idx_reg);
                if (idx_reg != '0 && above(v_reg, cur_val, side_reg))
                begin
                    // move parent down, keep climbing
                    wd       = cur_val;
                    idx_next = par;
                    state_next = S_SU_RD;
                end
                else
                begin
                    wd = v_reg;
                    if (idx_reg == '0)
                    begin
                        if (side_reg) ltop_next = v_reg;
                        else          utop_next = v_reg;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lsize_reg <= '0;
            usize_reg <= '0;
            done_reg  <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lsize_reg <= lsize_next;
            usize_reg <= usize_next;
            done_reg  <= done_next;
            drop_reg  <= drop_next;
        end
    end

    // payload of the sequencer
    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        carry_reg     <= carry_next;
        ltop_reg      <= ltop_next;
        utop_reg      <= utop_next;
        idx_reg       <= idx_next;
        n_reg         <= n_next;
        side_reg      <= side_next;
        push_side_reg <= push_side_next;
        op_reg        <= op_next;
    end

    logic [MEDIAN_W+VALUE_BITS-1:0] top_ext;
    assign top_ext = {{MEDIAN_W{1'b0}}, ltop_reg};

    assign busy       = (state_reg != S_IDLE) || done_reg;
    assign done       = done_reg && (op_reg == HOP_PUSH || op_reg == HOP_REPLACE);
    assign median     = (lsize_reg != '0) ? top_ext[MEDIAN_W-1:0] : '0;
    assign held_count = COUNT_W'(lsize_reg + usize_reg);
    assign dropped    = drop_reg;

endmodule

// ===== hdl/rmth_checker.sv =====
// rmth_checker: port-level checks for running_median_two_heap
// depends on rmth_pkg; bound to the top level below

module rmth_checker
    import rmth_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [COUNT_W-1:0]  held_count,
    input logic                dropped
);

    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");

    // an accepted item makes the block busy
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("item not taken");

    // a drop leaves the count unchanged
    a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dropped) |-> $stable(held_count)) else $error("count moved on drop");

    // the count only ever steps up by one
    a_keep_count: assert property (@(posedge clk) disable iff (!rst_n)
        (held_count != $past(held_count)) |-> held_count == $past(held_count) + 1'b1)
        else $error("count not grown by one");

endmodule

bind running_median_two_heap rmth_checker u_rmth_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .held_count(held_count), .dropped(dropped)
);

// ===== tb/running_median_two_heap_chk.sv =====
`timescale 1ns / 100ps
// running_median_two_heap_chk: watches the insert and result channels of the running median
// block, predicts each result from a sorted copy of the held values and compares it
// depends on rmth_pkg

module running_median_two_heap_chk
    import rmth_pkg::*;
#(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 17
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  done,
    input  logic [MEDIAN_W-1:0]   median,
    input  logic [COUNT_W-1:0]    held_count,
    input  logic                  dropped,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [MEDIAN_W-1:0] median;
        logic [COUNT_W-1:0]  held_count;
        logic                dropped;
    } median_result_t;

    // held values kept in ascending order; lower median is entry (n+1)/2 - 1
    logic [VALUE_BITS-1:0] held_sorted[$];
    median_result_t        expected_results[$];

    function automatic median_result_t insert_value(input logic [VALUE_BITS-1:0] v);
        median_result_t r;
        int pos;
        r.dropped = 1'b0;
        if (held_sorted.size() >= CAPACITY) begin
            r.dropped = 1'b1;
        end
        else begin
            pos = 0;
            while (pos < held_sorted.size() && held_sorted[pos] <= v)
                pos++;
            held_sorted.insert(pos, v);
        end
        r.held_count = COUNT_W'(held_sorted.size());
        if (held_sorted.size() == 0)
            r.median = '0;
        else
            r.median = MEDIAN_W'(held_sorted[(held_sorted.size() + 1) / 2 - 1]);
        return r;
    endfunction

    assign pending = expected_results.size();

    // predict on each accepted item, compare on each strobe
    always @(posedge clk or negedge rst_n)
    begin
        median_result_t got;
        median_result_t want;
        if (!rst_n) begin
            fail_count = 0;
            held_sorted.delete();
            expected_results.delete();
        end
        else begin
            if (done) begin
                got = '{median, held_count, dropped};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result median=%0d count=%0d dropped=%0b",
                             $time, median, held_count, dropped);
                    fail_count++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (got.median !== want.median) begin
                        $display("%0t: median expected %0d actual %0d",
                                 $time, want.median, got.median);
                        fail_count++;
                    end
                    if (got.held_count !== want.held_count) begin
                        $display("%0t: held_count expected %0d actual %0d",
                                 $time, want.held_count, got.held_count);
                        fail_count++;
                    end
                    if (got.dropped !== want.dropped) begin
                        $display("%0t: dropped expected %0b actual %0b",
                                 $time, want.dropped, got.dropped);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(insert_value(value));
        end
    end

endmodule

// ===== tb/running_median_two_heap_tb.sv =====
`timescale 1ns / 100ps
// running_median_two_heap_tb: drives inserts into the running median block and gives
// the verdict; depends on rmth_pkg, running_median_two_heap and running_median_two_heap_chk

module running_median_two_heap_tb;
    import rmth_pkg::*;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 17;
    localparam int VALUE_MAX  = (1 << VALUE_BITS) - 1;
    localparam int RANDOM_ITEMS = 1730;
    localparam int CYCLE_LIMIT  = 2000000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic [VALUE_BITS-1:0] value;
    logic                  busy;
    logic                  done;
    logic [MEDIAN_W-1:0]   median;
    logic [COUNT_W-1:0]    held_count;
    logic                  dropped;
    int                    fail_count;
    int                    pending;
    int                    cycle_count;

    running_median_two_heap #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .value(value), .busy(busy),
        .done(done), .median(median), .held_count(held_count), .dropped(dropped)
    );

    running_median_two_heap_chk #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .value(value),
        .done(done), .median(median), .held_count(held_count), .dropped(dropped),
        .fail_count(fail_count), .pending(pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // hold start high at the falling edge until the item is taken
    task automatic send_item(input logic [VALUE_BITS-1:0] v, input bit allow_idle);
        while (allow_idle && $urandom_range(99) < 17)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        value <= v;
        forever
        begin
            if (!busy) begin
                @(negedge clk);
                break;
            end
            @(negedge clk);
        end
    endtask

    initial
    begin
        logic [VALUE_BITS-1:0] v;
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, duplicates, first item into an empty store
        send_item(VALUE_BITS'(VALUE_MAX), 1'b0);
        send_item('0, 1'b0);
        send_item('0, 1'b0);
        send_item(VALUE_BITS'(VALUE_MAX), 1'b0);
        send_item(VALUE_BITS'(VALUE_MAX), 1'b0);
        send_item(17'h15555, 1'b0);
        send_item(17'h0AAAA, 1'b0);
        send_item(VALUE_BITS'(1), 1'b0);
        send_item(VALUE_BITS'(VALUE_MAX - 1), 1'b0);
        send_item(17'h10000, 1'b0);
        send_item(17'h0FFFF, 1'b0);
        send_item(17'h0FFFF, 1'b1);
        for (int i = 0; i < 8; i++)
            send_item(VALUE_BITS'(i * 9000), 1'b1);
        for (int i = 0; i < 5; i++)
            send_item(VALUE_BITS'(VALUE_MAX - i * 7000), 1'b1);

        // random: past capacity so the full-store drop is hit many times
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            case ($urandom_range(3))
                0: v = VALUE_BITS'($urandom_range(15));
                1: v = VALUE_BITS'($urandom_range(VALUE_MAX, VALUE_MAX - 15));
                default: v = VALUE_BITS'($urandom);
            endcase
            if (i == 300) begin
                start <= 1'b0;
                @(negedge clk);
                while (pending != 0)
                    @(negedge clk);
            end
            send_item(v, !(i >= 800 && i < 1000));
        end
        start <= 1'b0;

        // drain
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
